>>> rtl/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg - shared definitions for the track event parser
// Result kinds, field widths, the result record, a saturating add and a status helper.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int POSITION_BITS_DEF = 24;
	localparam int MAX_VLQ_BYTES     = 4;

	localparam int KIND_W  = 3;
	localparam int CODE_W  = 8;
	localparam int CHAN_W  = 4;
	localparam int DATA_W  = 7;
	localparam int DELTA_W = 32;
	localparam int OFF_W   = 24;
	localparam int LEN_W   = 7 * MAX_VLQ_BYTES;

	localparam logic [KIND_W-1:0] KIND_CHANNEL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_META    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SYSEX   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

	localparam logic [7:0] META_STATUS   = 8'hFF;
	localparam logic [7:0] META_END_TYPE = 8'h2F;
	localparam logic [3:0] SYS_NIBBLE    = 4'hF;
	localparam logic [3:0] NOTE_ON       = 4'h9;
	localparam logic [3:0] NOTE_RELEASE  = 4'h8;
	localparam logic [3:0] PROG_CHANGE   = 4'hC;
	localparam logic [3:0] CHAN_PRESSURE = 4'hD;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [CODE_W-1:0]  event_code;
		logic [CHAN_W-1:0]  channel;
		logic [DATA_W-1:0]  data_one;
		logic [DATA_W-1:0]  data_two;
		logic [DELTA_W-1:0] delta_ticks;
		logic [OFF_W-1:0]   data_offset;
		logic [LEN_W-1:0]   data_length;
		logic               run_last;
	} result_t;

	function automatic logic [DELTA_W-1:0] sat_add(input logic [DELTA_W-1:0] a,
			input logic [DELTA_W-1:0] b);
		logic [DELTA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DELTA_W] ? '1 : s[DELTA_W-1:0];
	endfunction

	// Status with a single data byte: program change and channel pressure.
	function automatic logic one_data_byte(input logic [7:0] status);
		return (status[7:4] == PROG_CHANGE) || (status[7:4] == CHAN_PRESSURE);
	endfunction

endpackage

>>> rtl/midi_track_event_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_top - track byte stream to event records
// Decodes delta times, running-status channel events, meta and sysex events
// and closes each track with an end record.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | track_byte, last_byte
//  out     | out_valid / out_ready| event_kind .. data_length, run_last
//  cfg     | cfg_write            | cfg_data (drop_end_markers)
//
//  One byte is taken per cycle while in_ready is high; the parser state
//  updates in the same cycle and the result lands in a single output register.
//  A byte that completes an event and also ends the track gives two results;
//  the track end enters the output register at the edge where the event is
//  taken, and in_ready stays low until then.
//  in_ready follows out_ready when the output register is full and no track
//  end is waiting.
//  arst_n clears all state but the result register; drop_end_markers resets to 1.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
	parameter int POSITION_BITS = mtep_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    track_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtep_pkg::KIND_W-1:0]   event_kind,
	output logic [mtep_pkg::CODE_W-1:0]   event_code,
	output logic [mtep_pkg::CHAN_W-1:0]   channel,
	output logic [mtep_pkg::DATA_W-1:0]   data_one,
	output logic [mtep_pkg::DATA_W-1:0]   data_two,
	output logic [mtep_pkg::DELTA_W-1:0]  delta_ticks,
	output logic [mtep_pkg::OFF_W-1:0]    data_offset,
	output logic [mtep_pkg::LEN_W-1:0]    data_length,
	output logic                          run_last
);
	import mtep_pkg::*;

	localparam logic [2:0] PH_DELTA    = 3'd0;
	localparam logic [2:0] PH_STATUS   = 3'd1;
	localparam logic [2:0] PH_DATA1    = 3'd2;
	localparam logic [2:0] PH_DATA2    = 3'd3;
	localparam logic [2:0] PH_METATYPE = 3'd4;
	localparam logic [2:0] PH_LENGTH   = 3'd5;
	localparam logic [2:0] PH_SKIP     = 3'd6;
	localparam logic [2:0] PH_DISCARD  = 3'd7;

	localparam logic [2:0] CNT_MAX = 3'd7;
	localparam logic [2:0] CNT_LIM = 3'(MAX_VLQ_BYTES);

	localparam result_t END_RES = '{event_kind: KIND_END, run_last: 1'b1, default: '0};

	logic                     drop_q;
	logic [2:0]               phase_q, phase_d;
	logic [7:0]               rs_q, rs_d;
	logic [DELTA_W-1:0]       delta_q, delta_d;
	logic [DELTA_W-1:0]       fold_q, fold_d;
	logic [2:0]               cnt_q, cnt_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [LEN_W-1:0]         skip_q, skip_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [KIND_W-1:0]        hkind_q, hkind_d;
	logic [CODE_W-1:0]        hcode_q, hcode_d;
	logic [DATA_W-1:0]        hfirst_q, hfirst_d;
	logic [POSITION_BITS-1:0] hoff_q, hoff_d;

	logic                     out_valid_q;
	logic                     end_pend_q;
	result_t                  res_q;

	logic [POSITION_BITS-1:0] pos_nx;
	logic                     accept;
	logic                     ev_valid;
	result_t                  ev;
	logic                     do_complete;
	logic [7:0]               second;
	logic [LEN_W-1:0]         cp_len;
	logic [2:0]               cnt_inc;
	logic [LEN_W-1:0]         len_new;
	logic [LEN_W-1:0]         skip_dec;
	logic [3:0]               ch_code;

	assign in_ready = !end_pend_q && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign pos_nx   = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		rs_d        = rs_q;
		delta_d     = delta_q;
		fold_d      = fold_q;
		cnt_d       = cnt_q;
		len_d       = len_q;
		skip_d      = skip_q;
		pos_d       = pos_nx;
		hkind_d     = hkind_q;
		hcode_d     = hcode_q;
		hfirst_d    = hfirst_q;
		hoff_d      = hoff_q;
		ev_valid    = 1'b0;
		ev          = '0;
		do_complete = 1'b0;
		second      = '0;
		cp_len      = '0;
		cnt_inc     = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 3'd1;
		len_new     = len_q;
		skip_dec    = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
		ch_code     = '0;

		unique case (phase_q)
			PH_DELTA: begin
				delta_d = (|delta_q[DELTA_W-1:DELTA_W-7]) ? '1
					: {delta_q[DELTA_W-8:0], track_byte[6:0]};
				if (!track_byte[7]) begin
					phase_d = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (track_byte == META_STATUS) begin
					hkind_d = KIND_META;
					phase_d = PH_METATYPE;
				end else if (track_byte[7:4] == SYS_NIBBLE) begin
					hkind_d = KIND_SYSEX;
					hcode_d = track_byte;
					hoff_d  = pos_nx;
					cnt_d   = '0;
					len_d   = '0;
					phase_d = PH_LENGTH;
				end else if (track_byte[7]) begin
					rs_d    = track_byte;
					hkind_d = KIND_CHANNEL;
					hoff_d  = pos_nx;
					phase_d = PH_DATA1;
				end else if (rs_q == '0) begin
					ev_valid       = 1'b1;
					ev.event_kind  = KIND_ERROR;
					ev.data_offset = OFF_W'(pos_q);
					phase_d        = PH_DISCARD;
				end else begin
					// running status: this byte is already the first data byte
					hkind_d  = KIND_CHANNEL;
					hoff_d   = pos_q;
					hfirst_d = track_byte[6:0];
					if (one_data_byte(rs_q)) begin
						do_complete = 1'b1;
					end else begin
						phase_d = PH_DATA2;
					end
				end
			end
			PH_DATA1: begin
				hfirst_d = track_byte[6:0];
				if (one_data_byte(rs_q)) begin
					do_complete = 1'b1;
				end else begin
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				do_complete = 1'b1;
				second      = track_byte;
			end
			PH_METATYPE: begin
				hcode_d = track_byte;
				hoff_d  = pos_nx;
				cnt_d   = '0;
				len_d   = '0;
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				if (cnt_q < CNT_LIM) begin
					len_new = {len_q[LEN_W-8:0], track_byte[6:0]};
				end
				len_d = len_new;
				cnt_d = cnt_inc;
				if (!track_byte[7]) begin
					// lengths longer than the VLQ limit count as zero
					if (cnt_inc > CNT_LIM || len_new == '0) begin
						do_complete = 1'b1;
					end else begin
						skip_d  = len_new;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					do_complete = 1'b1;
					cp_len      = len_q;
				end
			end
			PH_DISCARD: begin
			end
			default: begin
			end
		endcase

		if (do_complete) begin
			if (hkind_d == KIND_META && hcode_d == META_END_TYPE && drop_q) begin
				// fold the end marker's delta into the next event
				fold_d = sat_add(fold_q, delta_q);
			end else begin
				ev_valid       = 1'b1;
				fold_d         = '0;
				ev.delta_ticks = sat_add(fold_q, delta_q);
				ev.data_offset = OFF_W'(hoff_d);
				if (hkind_d == KIND_CHANNEL) begin
					ch_code = rs_d[7:4];
					if (ch_code == NOTE_ON && second == '0) begin
						ch_code = NOTE_RELEASE;
					end
					ev.event_kind = KIND_CHANNEL;
					ev.event_code = {ch_code, 4'h0};
					ev.channel    = rs_d[3:0];
					ev.data_one   = hfirst_d;
					ev.data_two   = second[6:0];
				end else begin
					ev.event_kind  = hkind_d;
					ev.event_code  = hcode_d;
					ev.data_length = cp_len;
				end
			end
			phase_d = PH_DELTA;
			delta_d = '0;
			cnt_d   = '0;
			len_d   = '0;
			skip_d  = '0;
		end

		ev.run_last = !last_byte;

		if (last_byte) begin
			phase_d  = PH_DELTA;
			rs_d     = '0;
			delta_d  = '0;
			fold_d   = '0;
			cnt_d    = '0;
			len_d    = '0;
			skip_d   = '0;
			pos_d    = '0;
			hkind_d  = '0;
			hcode_d  = '0;
			hfirst_d = '0;
			hoff_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q   <= 1'b1;
			phase_q  <= PH_DELTA;
			rs_q     <= '0;
			delta_q  <= '0;
			fold_q   <= '0;
			cnt_q    <= '0;
			len_q    <= '0;
			skip_q   <= '0;
			pos_q    <= '0;
			hkind_q  <= '0;
			hcode_q  <= '0;
			hfirst_q <= '0;
			hoff_q   <= '0;
		end else begin
			if (cfg_write) begin
				drop_q <= cfg_data;
			end
			if (accept) begin
				phase_q  <= phase_d;
				rs_q     <= rs_d;
				delta_q  <= delta_d;
				fold_q   <= fold_d;
				cnt_q    <= cnt_d;
				len_q    <= len_d;
				skip_q   <= skip_d;
				pos_q    <= pos_d;
				hkind_q  <= hkind_d;
				hcode_q  <= hcode_d;
				hfirst_q <= hfirst_d;
				hoff_q   <= hoff_d;
			end
		end
	end

	// Output register control; end_pend_q holds a track end behind an event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			end_pend_q  <= 1'b0;
		end else if (accept) begin
			out_valid_q <= ev_valid || last_byte;
			end_pend_q  <= ev_valid && last_byte;
		end else if (end_pend_q && out_ready) begin
			end_pend_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= ev_valid ? ev : END_RES;
		end else if (end_pend_q && out_ready) begin
			res_q <= END_RES;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = res_q.event_kind;
	assign event_code  = res_q.event_code;
	assign channel     = res_q.channel;
	assign data_one    = res_q.data_one;
	assign data_two    = res_q.data_two;
	assign delta_ticks = res_q.delta_ticks;
	assign data_offset = res_q.data_offset;
	assign data_length = res_q.data_length;
	assign run_last    = res_q.run_last;

endmodule

>>> tb/sv/midi_track_event_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_top_tb - self-checking bench for the track parser
// Feeds whole tracks, mostly well formed with random content plus noise and
// cut-off tracks, through the byte channel. A behavioral decoder predicts the
// event records, and a monitor checks every field of each record in order.
// Both handshakes idle at random, and the receiver holds off once for a long
// stretch. The end-marker mode is switched between batches of tracks.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top_tb;
	import mtep_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int BYTES_PER_BATCH = 315;

	typedef enum logic [3:0] {
		AT_DELTA, AT_STATUS, AT_DATA1, AT_DATA2, AT_META_TYPE, AT_LENGTH, AT_SKIP, AT_DISCARD
	} parse_at_e;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} track_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] track_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] event_kind;
	logic [CODE_W-1:0] event_code;
	logic [CHAN_W-1:0] channel;
	logic [DATA_W-1:0] data_one;
	logic [DATA_W-1:0] data_two;
	logic [DELTA_W-1:0] delta_ticks;
	logic [OFF_W-1:0] data_offset;
	logic [LEN_W-1:0] data_length;
	logic run_last;

	midi_track_event_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.track_byte(track_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .event_code(event_code), .channel(channel),
		.data_one(data_one), .data_two(data_two), .delta_ticks(delta_ticks),
		.data_offset(data_offset), .data_length(data_length), .run_last(run_last)
	);

	always #5 clk = ~clk;

	track_item_t pending_bytes[$];
	result_t expected_events[$];
	logic [7:0] trk[$];
	int trk_tail;

	int bytes_queued = 0;
	int bytes_accepted = 0;
	int phase_bytes = 0;
	int tracks_queued = 0;
	int events_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int kind_seen[8] = '{default: 0};
	int stall_left = 0;
	logic stall_done = 1'b0;
	logic steady;
	track_item_t next_item;
	result_t want_event;

	// decoder state
	parse_at_e parse_at;
	logic [7:0] run_status;
	logic [31:0] delta_sum;
	logic [31:0] fold_sum;
	logic [2:0] len_bytes;
	logic [31:0] len_sum;
	logic [31:0] skip_left;
	logic [OFF_W-1:0] byte_pos;
	logic [KIND_W-1:0] hold_kind;
	logic [7:0] hold_code;
	logic [7:0] hold_first;
	logic [OFF_W-1:0] hold_off;
	logic drop_end_model;

	// no idling on either side for a stretch in the middle of the run
	assign steady = (bytes_accepted >= 600) && (bytes_accepted < 850);

	function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] s;
		s = a + b;
		return (s < a) ? 32'hFFFF_FFFF : s;
	endfunction

	function automatic void clear_track();
		parse_at = AT_DELTA;
		run_status = '0;
		delta_sum = '0;
		fold_sum = '0;
		len_bytes = '0;
		len_sum = '0;
		skip_left = '0;
		byte_pos = '0;
		hold_kind = '0;
		hold_code = '0;
		hold_first = '0;
		hold_off = '0;
	endfunction

	function automatic void push_event(input logic [2:0] kind, input logic [7:0] code,
			input logic [3:0] chan, input logic [6:0] d1, input logic [6:0] d2,
			input logic [31:0] delta, input logic [23:0] off, input logic [27:0] len);
		result_t r;
		r.event_kind = kind;
		r.event_code = code;
		r.channel = chan;
		r.data_one = d1;
		r.data_two = d2;
		r.delta_ticks = delta;
		r.data_offset = off;
		r.data_length = len;
		r.run_last = 1'b0;
		expected_events.push_back(r);
	endfunction

	function automatic void finish_event(input logic [7:0] second, input logic [27:0] len);
		logic [31:0] delta;
		logic [7:0] code;
		if (hold_kind == KIND_META && hold_code == META_END_TYPE && drop_end_model) begin
			// fold the end marker's delta into whatever event comes next
			fold_sum = add_clamped(fold_sum, delta_sum);
		end else begin
			delta = add_clamped(fold_sum, delta_sum);
			fold_sum = '0;
			if (hold_kind == KIND_CHANNEL) begin
				code = {run_status[7:4], 4'h0};
				// full byte compare: a velocity of 0x80 stays a note-on
				if (run_status[7:4] == NOTE_ON && second == 8'h00)
					code = {NOTE_RELEASE, 4'h0};
				push_event(KIND_CHANNEL, code, run_status[3:0], hold_first[6:0], second[6:0],
						delta, hold_off, '0);
			end else begin
				push_event(hold_kind, hold_code, '0, '0, '0, delta, hold_off, len);
			end
		end
		parse_at = AT_DELTA;
		delta_sum = '0;
		len_bytes = '0;
		len_sum = '0;
		skip_left = '0;
	endfunction

	function automatic void decode_track_byte(input logic [7:0] b, input logic last);
		logic [OFF_W-1:0] here;
		logic [31:0] size_val;
		logic short_event;
		int unsigned queued;
		result_t r;
		here = byte_pos;
		queued = expected_events.size();
		if (byte_pos != '1)
			byte_pos = byte_pos + 1'b1;
		short_event = (run_status[7:4] == PROG_CHANGE) || (run_status[7:4] == CHAN_PRESSURE);
		case (parse_at)
			AT_DELTA: begin
				if (delta_sum > 32'h01FF_FFFF)
					delta_sum = 32'hFFFF_FFFF;
				else
					delta_sum = {delta_sum[24:0], b[6:0]};
				if (!b[7])
					parse_at = AT_STATUS;
			end
			AT_STATUS: begin
				if (b == META_STATUS) begin
					hold_kind = KIND_META;
					parse_at = AT_META_TYPE;
				end else if (b[7:4] == SYS_NIBBLE) begin
					hold_kind = KIND_SYSEX;
					hold_code = b;
					hold_off = byte_pos;
					len_bytes = '0;
					len_sum = '0;
					parse_at = AT_LENGTH;
				end else if (b[7]) begin
					run_status = b;
					hold_kind = KIND_CHANNEL;
					hold_off = byte_pos;
					parse_at = AT_DATA1;
				end else if (run_status == 8'h00) begin
					push_event(KIND_ERROR, '0, '0, '0, '0, '0, here, '0);
					parse_at = AT_DISCARD;
				end else begin
					hold_kind = KIND_CHANNEL;
					hold_off = here;
					hold_first = b;
					if (short_event)
						finish_event(8'h00, '0);
					else
						parse_at = AT_DATA2;
				end
			end
			AT_DATA1: begin
				hold_first = b;
				if (short_event)
					finish_event(8'h00, '0);
				else
					parse_at = AT_DATA2;
			end
			AT_DATA2: finish_event(b, '0);
			AT_META_TYPE: begin
				hold_code = b;
				hold_off = byte_pos;
				len_bytes = '0;
				len_sum = '0;
				parse_at = AT_LENGTH;
			end
			AT_LENGTH: begin
				if (len_bytes < MAX_VLQ_BYTES)
					len_sum = {len_sum[24:0], b[6:0]};
				if (len_bytes < 3'd7)
					len_bytes = len_bytes + 1'b1;
				if (!b[7]) begin
					size_val = (len_bytes <= MAX_VLQ_BYTES) ? len_sum : 32'h0;
					if (size_val == 0) begin
						finish_event(8'h00, '0);
					end else begin
						skip_left = size_val;
						len_sum = size_val;
						parse_at = AT_SKIP;
					end
				end
			end
			AT_SKIP: begin
				if (skip_left != 0)
					skip_left = skip_left - 1;
				if (skip_left == 0)
					finish_event(8'h00, len_sum[27:0]);
			end
			default: ;
		endcase
		if (last) begin
			push_event(KIND_END, '0, '0, '0, '0, '0, '0, '0);
			clear_track();
		end
		if (expected_events.size() > queued) begin
			r = expected_events.pop_back();
			r.run_last = 1'b1;
			expected_events.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------- stimulus construction ----------------

	task automatic queue_byte(input logic [7:0] b, input logic last);
		pending_bytes.push_back('{value: b, last: last});
		bytes_queued++;
		phase_bytes++;
	endtask

	task automatic add_vlq(input logic [31:0] v, input int pad);
		int groups;
		int i;
		logic [31:0] grp;
		groups = 1;
		while (groups < 5 && (v >> (7 * groups)) != 0)
			groups++;
		for (i = groups + pad - 1; i >= 0; i--) begin
			grp = v >> (7 * i);
			trk.push_back({(i > 0) ? 1'b1 : 1'b0, grp[6:0]});
		end
	endtask

	task automatic add_delta();
		int r;
		int k;
		int i;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			add_vlq($urandom_range(0, 127), 0);
		end else if (r < 75) begin
			add_vlq($urandom_range(128, 16383), 0);
		end else if (r < 85) begin
			add_vlq($urandom_range(0, 32'h0FFF_FFFF), 0);
		end else if (r < 92) begin
			add_vlq($urandom, 0);
		end else if (r < 96) begin
			add_vlq($urandom_range(0, 127), $urandom_range(1, 3));
		end else begin
			// long enough to push the delta past 32 bits
			k = $urandom_range(5, 7);
			for (i = 0; i < k; i++)
				trk.push_back({1'b1, 7'($urandom_range(64, 127))});
			trk.push_back({1'b0, 7'($urandom)});
		end
	endtask

	task automatic add_length_and_payload();
		int r;
		int len;
		int k;
		int i;
		r = $urandom_range(0, 99);
		len = 0;
		if (r < 65) begin
			len = $urandom_range(0, 6);
			add_vlq(len, 0);
		end else if (r < 77) begin
			len = $urandom_range(0, 6);
			add_vlq(len, $urandom_range(1, 3));
		end else if (r < 85) begin
			len = $urandom_range(128, 180);
			add_vlq(len, 0);
		end else if (r < 93) begin
			// five or more length bytes: taken as an empty payload
			k = $urandom_range(4, 6);
			for (i = 0; i < k; i++)
				trk.push_back({1'b1, 7'($urandom)});
			trk.push_back({1'b0, 7'($urandom)});
		end else begin
			trk.push_back(8'h00);
		end
		for (i = 0; i < len; i++)
			trk.push_back(8'($urandom));
	endtask

	function automatic logic [7:0] pick_data();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
				: 8'($urandom_range(0, 127));
	endfunction

	task automatic add_event(inout logic [7:0] rs);
		int r;
		add_delta();
		r = $urandom_range(0, 99);
		if (r < 60) begin
			if (r < 20 && rs != 8'h00) begin
				trk.push_back(8'($urandom_range(0, 127)));
			end else begin
				rs = 8'($urandom_range(8'h80, 8'hEF));
				trk.push_back(rs);
				trk.push_back(pick_data());
			end
			if (rs[7:4] != PROG_CHANGE && rs[7:4] != CHAN_PRESSURE) begin
				if (rs[7:4] == NOTE_ON && $urandom_range(0, 3) == 0)
					trk.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
				else
					trk.push_back(pick_data());
			end
		end else if (r < 80) begin
			trk.push_back(META_STATUS);
			trk.push_back(($urandom_range(0, 2) == 0) ? META_END_TYPE : 8'($urandom));
			add_length_and_payload();
		end else begin
			trk.push_back(8'($urandom_range(8'hF0, 8'hFE)));
			add_length_and_payload();
		end
	endtask

	task automatic queue_track();
		int r;
		int n;
		int i;
		int stop;
		logic [7:0] rs;
		trk.delete();
		rs = 8'h00;
		trk_tail = 0;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			n = $urandom_range(1, 24);
			for (i = 0; i < n; i++)
				trk.push_back(8'($urandom));
		end else begin
			if (r < 10) begin
				// data byte before any status: error, then the rest is dropped
				add_delta();
				trk.push_back(8'($urandom_range(0, 127)));
			end
			n = $urandom_range(1, 10);
			for (i = 0; i < n; i++) begin
				trk_tail = trk.size();
				add_event(rs);
			end
			r = $urandom_range(0, 99);
			if (r >= 75 && r < 88)
				trk.push_back(8'($urandom));
		end
		stop = trk.size() - 1;
		// cut the final event short
		if (r >= 88)
			stop = $urandom_range(trk_tail, trk.size() - 1);
		for (i = 0; i <= stop; i++)
			queue_byte(trk[i], i == stop);
		tracks_queued++;
	endtask

	task automatic queue_random_tracks();
		phase_bytes = 0;
		while (phase_bytes < BYTES_PER_BATCH)
			queue_track();
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (bytes_accepted != bytes_queued || expected_events.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_drop_markers(input logic v);
		wait_drained();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		drop_end_model = v;
	endtask

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			track_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_track_byte(track_byte, last_byte);
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					track_byte <= next_item.value;
					last_byte <= next_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!stall_done && bytes_accepted >= 400 && pending_bytes.size() >= 200) begin
			// hold off long enough for the input side to back up
			out_ready <= 1'b0;
			stall_left <= 160;
			stall_done <= 1'b1;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				$error("event_kind: expected no result, got %0h", event_kind);
				mismatches++;
			end else begin
				want_event = expected_events.pop_front();
				check_field("event_kind", want_event.event_kind, event_kind);
				check_field("event_code", want_event.event_code, event_code);
				check_field("channel", want_event.channel, channel);
				check_field("data_one", want_event.data_one, data_one);
				check_field("data_two", want_event.data_two, data_two);
				check_field("delta_ticks", want_event.delta_ticks, delta_ticks);
				check_field("data_offset", want_event.data_offset, data_offset);
				check_field("data_length", want_event.data_length, data_length);
				check_field("run_last", want_event.run_last, run_last);
				kind_seen[want_event.event_kind]++;
				events_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("midi_track_event_parser_top_tb NOT OK");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		logic [7:0] no_status_track [4];
		logic [7:0] sample_track [23];
		no_status_track = '{8'h00, 8'h45, 8'h9F, 8'hFF};
		// note-on at velocity zero, longest four-byte delta with running status,
		// program change with a high data bit, a dropped end marker, a sysex
		// that picks up the folded delta, and an event closed by the last byte
		sample_track = '{8'h00, 8'h90, 8'h3C, 8'h00,
				8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F,
				8'h00, 8'hCF, 8'hFF,
				8'h05, 8'hFF, 8'h2F, 8'h00,
				8'h01, 8'hF7, 8'h01, 8'hAB,
				8'h00, 8'h42};
		clear_track();
		drop_end_model = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (no_status_track[i])
			queue_byte(no_status_track[i], i == 3);
		foreach (sample_track[i])
			queue_byte(sample_track[i], i == 22);
		tracks_queued += 2;
		queue_random_tracks();

		set_drop_markers(1'b0);
		queue_random_tracks();
		set_drop_markers(1'b1);
		queue_random_tracks();
		set_drop_markers(1'b0);
		queue_random_tracks();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d tracks, %0d bytes; %0d results checked", tracks_queued, bytes_accepted,
				events_checked);
		$display("channel %0d, meta %0d, sysex %0d, track end %0d, missing status %0d",
				kind_seen[KIND_CHANNEL], kind_seen[KIND_META], kind_seen[KIND_SYSEX],
				kind_seen[KIND_END], kind_seen[KIND_ERROR]);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("midi_track_event_parser_top_tb OK");
		else
			$display("midi_track_event_parser_top_tb NOT OK");
		$finish;
	end

endmodule
